@@ src/aarm_pkg.sv @@
`timescale 1ns / 1ps

package aarm_pkg;

    localparam int CORDIC_STAGES_DEF   = 24;
    localparam int ENTRY_FRAC_BITS_DEF = 30;

    // axis normalization pipeline
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_STAGES  = 16;
    localparam int NORM_LAT    = 5 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

    typedef struct packed {
        logic valid;
        logic axis_zero;
    } ctl_t;

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // atan(2^-i) in q2.30, rounded
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        case (i)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            default: r = 34'sd1 <<< (30 - i);
        endcase
        return r;
    endfunction

    // q1.30 product, round half up
    function automatic logic signed [35:0] mulq(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        p = p + (68'sd1 <<< 29);
        return 36'(p >>> 30);
    endfunction

endpackage

@@ src/axis_angle_rotation_matrix_unit.sv @@
`timescale 1ns / 1ps

// channel | signals                                  | beat
// --------+------------------------------------------+-------------------------------
// in      | in_valid in_ready angle_rad axis_x..z    | one angle and axis
// out     | out_valid out_ready m00..m22 axis_error  | nine matrix entries and flag
//
// one beat per cycle while the output is not stalled; the pipeline depth is set by the axis
// normalization: 16 square root stages of two bits each, then 16 divider stages of up to
// two bits each
// the cordic path runs alongside and is delayed to meet the normalized axis
// reset clears only the valid bits; no warm-up, a beat may enter right after reset
// a stalled output freezes the whole pipeline; in_ready = !out_valid || out_ready

module axis_angle_rotation_matrix_unit #(
    parameter int CORDIC_STAGES   = aarm_pkg::CORDIC_STAGES_DEF,
    parameter int ENTRY_FRAC_BITS = aarm_pkg::ENTRY_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] angle_rad,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m02,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic signed [31:0] m20,
    output logic signed [31:0] m21,
    output logic signed [31:0] m22,
    output logic               axis_error
);

    localparam int          DLY     = aarm_pkg::NORM_LAT - (CORDIC_STAGES + 3);
    localparam logic [31:0] ONE_OUT = 32'd1 << ENTRY_FRAC_BITS;

    logic               en;
    aarm_pkg::ctl_t     norm_ctl;
    aarm_pkg::ctl_t     mat_ctl;
    logic signed [31:0] u_x;
    logic signed [31:0] u_y;
    logic signed [31:0] u_z;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] c_dly_reg [DLY];
    logic signed [31:0] s_dly_reg [DLY];
    logic [31:0]        m [9];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    aarm_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .axis_x   (axis_x),
        .axis_y   (axis_y),
        .axis_z   (axis_z),
        .ctl      (norm_ctl),
        .u_x      (u_x),
        .u_y      (u_y),
        .u_z      (u_z)
    );

    aarm_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .en        (en),
        .angle_rad (angle_rad),
        .c         (c),
        .s         (s)
    );

    // align sine and cosine with the normalized axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_dly_reg[0] <= c;
            s_dly_reg[0] <= s;
            for (int i = 1; i < DLY; i++)
            begin
                c_dly_reg[i] <= c_dly_reg[i-1];
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
        end
    end

    aarm_mat #(
        .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
    ) u_mat (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (norm_ctl),
        .c       (c_dly_reg[DLY-1]),
        .s       (s_dly_reg[DLY-1]),
        .u_x     (u_x),
        .u_y     (u_y),
        .u_z     (u_z),
        .out_ctl (mat_ctl),
        .m       (m)
    );

    assign out_valid  = mat_ctl.valid;
    assign axis_error = mat_ctl.axis_zero;
    assign m00        = m[0];
    assign m01        = m[1];
    assign m02        = m[2];
    assign m10        = m[3];
    assign m11        = m[4];
    assign m12        = m[5];
    assign m20        = m[6];
    assign m21        = m[7];
    assign m22        = m[8];

    a_error_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && axis_error |->
            m00 == ONE_OUT && m11 == ONE_OUT && m22 == ONE_OUT &&
            m01 == 32'sd0 && m02 == 32'sd0 && m10 == 32'sd0 &&
            m12 == 32'sd0 && m20 == 32'sd0 && m21 == 32'sd0)
        else $error("zero axis beat is not the identity");

    a_diag_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !axis_error |->
            m00 <= $signed(ONE_OUT) && m00 >= -$signed(ONE_OUT) &&
            m11 <= $signed(ONE_OUT) && m11 >= -$signed(ONE_OUT) &&
            m22 <= $signed(ONE_OUT) && m22 >= -$signed(ONE_OUT))
        else $error("diagonal entry out of unit range");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline refuses a beat with an empty output");

endmodule

@@ src/aarm_norm.sv @@
`timescale 1ns / 1ps

module aarm_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [31:0]  axis_x,
    input  logic signed [31:0]  axis_y,
    input  logic signed [31:0]  axis_z,
    output aarm_pkg::ctl_t      ctl,
    output logic signed [31:0]  u_x,
    output logic signed [31:0]  u_y,
    output logic signed [31:0]  u_z
);

    localparam int LAT = aarm_pkg::NORM_LAT;
    localparam int SQS = aarm_pkg::SQRT_STAGES;
    localparam int DVS = aarm_pkg::DIV_STAGES;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } side_t;

    logic [LAT-1:0] vld_reg;
    side_t          side_reg [LAT];
    side_t          side_next;
    logic [31:0]    comp [3];

    assign comp[0] = axis_x;
    assign comp[1] = axis_y;
    assign comp[2] = axis_z;

    always_comb
    begin
        side_next.zero = (axis_x == 32'sd0) && (axis_y == 32'sd0) && (axis_z == 32'sd0);
        side_next.neg  = {axis_z[31], axis_y[31], axis_x[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // magnitudes, largest magnitude
    logic [31:0] mag1_reg [3];
    logic [31:0] mag1_next [3];
    logic [31:0] mx1_reg;
    logic [31:0] mx1_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag1_next[k] = comp[k][31] ? 32'(-comp[k]) : comp[k];
        end
        mx1_next = mag1_next[0];
        if (mag1_next[1] > mx1_next)
        begin
            mx1_next = mag1_next[1];
        end
        if (mag1_next[2] > mx1_next)
        begin
            mx1_next = mag1_next[2];
        end
    end

    // shift count, shift, squares, sum
    logic [31:0] mag2_reg [3];
    logic [4:0]  sh2_reg;
    logic [4:0]  sh2_next;
    logic [31:0] mag3_reg [3];
    logic [31:0] mag4_reg [3];
    logic [63:0] sq4_reg [3];

    always_comb
    begin
        if (mx1_reg[31:30] != 2'b00)
        begin
            sh2_next = 5'd0;
        end
        else
        begin
            sh2_next = 5'(aarm_pkg::lead_zeros(mx1_reg) - 6'd1);
        end
    end

    // square root, two result bits per stage
    logic [63:0] rad_reg  [SQS+1];
    logic [35:0] rem_reg  [SQS+1];
    logic [31:0] root_reg [SQS+1];
    logic [31:0] smag_reg [SQS+1][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag1_next;
            mx1_reg  <= mx1_next;
            mag2_reg <= mag1_reg;
            sh2_reg  <= sh2_next;
            for (int k = 0; k < 3; k++)
            begin
                mag3_reg[k] <= mag2_reg[k] << sh2_reg;
                sq4_reg[k]  <= 64'(mag3_reg[k]) * 64'(mag3_reg[k]);
            end
            mag4_reg    <= mag3_reg;
            rad_reg[0]  <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            smag_reg[0] <= mag4_reg;
        end
    end

    for (genvar s = 0; s < SQS; s++)
    begin : g_sqrt
        logic [35:0] rem_next;
        logic [31:0] root_next;
        logic [35:0] trial;

        always_comb
        begin
            rem_next  = rem_reg[s];
            root_next = root_reg[s];
            trial     = '0;
            for (int m = 0; m < 2; m++)
            begin
                rem_next = {rem_next[33:0], rad_reg[s][63 - 2 * (2 * s + m) -: 2]};
                trial    = {2'b00, root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[30:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s+1]  <= rad_reg[s];
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                smag_reg[s+1] <= smag_reg[s];
            end
        end
    end

    // dividers, up to two quotient bits per stage
    logic [61:0] num_reg [DVS+1][3];
    logic [31:0] drem_reg [DVS+1][3];
    logic [30:0] quo_reg [DVS+1][3];
    logic [31:0] den_reg [DVS+1];
    logic [61:0] num_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_next[k] = {smag_reg[SQS][k], 30'd0} + 62'(root_reg[SQS] >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= root_reg[SQS];
            for (int k = 0; k < 3; k++)
            begin
                num_reg[0][k]  <= num_next[k];
                drem_reg[0][k] <= {1'b0, num_next[k][61:31]};
                quo_reg[0][k]  <= '0;
            end
        end
    end

    for (genvar d = 0; d < DVS; d++)
    begin : g_div
        logic [31:0] rem_next [3];
        logic [30:0] quo_next [3];
        logic [32:0] r;

        always_comb
        begin
            r = '0;
            for (int k = 0; k < 3; k++)
            begin
                rem_next[k] = drem_reg[d][k];
                quo_next[k] = quo_reg[d][k];
                for (int m = 0; m < 2; m++)
                begin
                    if (2 * d + m < aarm_pkg::DIV_STEPS)
                    begin
                        r = {rem_next[k], num_reg[d][k][30 - (2 * d + m)]};
                        if (r >= {1'b0, den_reg[d]})
                        begin
                            r = r - {1'b0, den_reg[d]};
                            quo_next[k][30 - (2 * d + m)] = 1'b1;
                        end
                        rem_next[k] = r[31:0];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[d+1]  <= den_reg[d];
                num_reg[d+1]  <= num_reg[d];
                drem_reg[d+1] <= rem_next;
                quo_reg[d+1]  <= quo_next;
            end
        end
    end

    // restore signs
    logic signed [31:0] u_reg [3];
    logic signed [31:0] u_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_next[k] = side_reg[LAT-2].neg[k] ? -$signed({1'b0, quo_reg[DVS][k]})
                                                :  $signed({1'b0, quo_reg[DVS][k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= u_next;
        end
    end

    assign u_x           = u_reg[0];
    assign u_y           = u_reg[1];
    assign u_z           = u_reg[2];
    assign ctl.valid     = vld_reg[LAT-1];
    assign ctl.axis_zero = side_reg[LAT-1].zero;

endmodule

@@ src/aarm_cordic.sv @@
`timescale 1ns / 1ps

module aarm_cordic #(
    parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] angle_rad,
    output logic signed [31:0] c,
    output logic signed [31:0] s
);

    localparam int N = CORDIC_STAGES;

    logic signed [33:0] a1_reg;
    logic signed [33:0] a1_next;
    logic signed [33:0] a2;
    logic               neg2;
    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic               neg_reg [N+1];

    // reduce into [-pi, pi)
    always_comb
    begin
        a1_next = 34'(angle_rad);
        if (a1_next >= aarm_pkg::PI_Q28)
        begin
            a1_next = a1_next - aarm_pkg::TWO_PI_Q28;
        end
        else if (a1_next < -aarm_pkg::PI_Q28)
        begin
            a1_next = a1_next + aarm_pkg::TWO_PI_Q28;
        end
    end

    // fold by a half turn into [-pi/2, pi/2]
    always_comb
    begin
        a2   = a1_reg;
        neg2 = 1'b0;
        if (a1_reg > aarm_pkg::HALF_PI_Q28)
        begin
            a2   = a1_reg - aarm_pkg::PI_Q28;
            neg2 = 1'b1;
        end
        else if (a1_reg < -aarm_pkg::HALF_PI_Q28)
        begin
            a2   = a1_reg + aarm_pkg::PI_Q28;
            neg2 = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg     <= a1_next;
            x_reg[0]   <= aarm_pkg::GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= a2 <<< 2;
            neg_reg[0] <= neg2;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [33:0] x_next;
        logic signed [33:0] y_next;
        logic signed [33:0] z_next;

        always_comb
        begin
            if (z_reg[i] >= 34'sd0)
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - aarm_pkg::atan_q30(i);
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + aarm_pkg::atan_q30(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic signed [33:0] cc;
    logic signed [33:0] sc;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;

    always_comb
    begin
        cc = x_reg[N];
        sc = y_reg[N];
        if (cc > 34'sd1073741824)
        begin
            cc = 34'sd1073741824;
        end
        else if (cc < -34'sd1073741824)
        begin
            cc = -34'sd1073741824;
        end
        if (sc > 34'sd1073741824)
        begin
            sc = 34'sd1073741824;
        end
        else if (sc < -34'sd1073741824)
        begin
            sc = -34'sd1073741824;
        end
        if (neg_reg[N])
        begin
            cc = -cc;
            sc = -sc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= 32'(cc);
            s_reg <= 32'(sc);
        end
    end

    assign c = c_reg;
    assign s = s_reg;

endmodule

@@ src/aarm_mat.sv @@
`timescale 1ns / 1ps

module aarm_mat #(
    parameter int ENTRY_FRAC_BITS = aarm_pkg::ENTRY_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  aarm_pkg::ctl_t     in_ctl,
    input  logic signed [31:0] c,
    input  logic signed [31:0] s,
    input  logic signed [31:0] u_x,
    input  logic signed [31:0] u_y,
    input  logic signed [31:0] u_z,
    output aarm_pkg::ctl_t     out_ctl,
    output logic [31:0]        m [9]
);

    localparam int          SH      = 30 - ENTRY_FRAC_BITS;
    localparam int          RND_SH  = (SH > 0) ? SH - 1 : 0;
    localparam logic [31:0] ONE_OUT = 32'd1 << ENTRY_FRAC_BITS;

    logic [2:0] vld_reg;
    logic [2:0] zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_ctl.valid};
        end
    end

    logic signed [33:0] u0 [3];
    logic signed [33:0] t0;

    assign u0[0] = 34'(u_x);
    assign u0[1] = 34'(u_y);
    assign u0[2] = 34'(u_z);
    assign t0    = 34'sd1073741824 - 34'(c);

    // t*u and s*u
    logic signed [35:0] tu1_reg [3];
    logic signed [35:0] su1_reg [3];
    logic signed [33:0] u1_reg [3];
    logic signed [31:0] c1_reg;
    // t*u*u
    logic signed [35:0] p2_reg [3][3];
    logic signed [35:0] su2_reg [3];
    logic signed [31:0] c2_reg;
    logic [31:0]        m3_reg [9];
    logic [31:0]        m3_next [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[1:0], in_ctl.axis_zero};
            for (int k = 0; k < 3; k++)
            begin
                tu1_reg[k] <= aarm_pkg::mulq(t0, u0[k]);
                su1_reg[k] <= aarm_pkg::mulq(34'(s), u0[k]);
            end
            u1_reg  <= u0;
            c1_reg  <= c;
            for (int cl = 0; cl < 3; cl++)
            begin
                for (int rw = 0; rw < 3; rw++)
                begin
                    p2_reg[cl][rw] <= aarm_pkg::mulq(34'(tu1_reg[cl]), u1_reg[rw]);
                end
            end
            su2_reg <= su1_reg;
            c2_reg  <= c1_reg;
            m3_reg  <= m3_next;
        end
    end

    logic signed [35:0] v;

    always_comb
    begin
        v = '0;
        for (int cl = 0; cl < 3; cl++)
        begin
            for (int rw = 0; rw < 3; rw++)
            begin
                if (cl == rw)
                begin
                    v = p2_reg[cl][rw] + 36'(c2_reg);
                end
                else if (rw == (cl + 1) % 3)
                begin
                    v = p2_reg[cl][rw] + su2_reg[3 - cl - rw];
                end
                else
                begin
                    v = p2_reg[cl][rw] - su2_reg[3 - cl - rw];
                end
                if (v > aarm_pkg::ONE_Q30)
                begin
                    v = aarm_pkg::ONE_Q30;
                end
                else if (v < -aarm_pkg::ONE_Q30)
                begin
                    v = -aarm_pkg::ONE_Q30;
                end
                if (SH > 0)
                begin
                    v = (v + (36'sd1 <<< RND_SH)) >>> SH;
                end
                if (zero_reg[1])
                begin
                    m3_next[cl * 3 + rw] = (cl == rw) ? ONE_OUT : 32'd0;
                end
                else
                begin
                    m3_next[cl * 3 + rw] = 32'(v);
                end
            end
        end
    end

    assign m                 = m3_reg;
    assign out_ctl.valid     = vld_reg[2];
    assign out_ctl.axis_zero = zero_reg[2];

endmodule
